[hdl/sla_pkg.sv]
// Shared types and constants for the stack panel arrange block.
package sla_pkg;

   localparam int LEN_W = 16;
   localparam int POS_W = 20;
   localparam int CSR_IDX_W = 2;

   localparam logic [POS_W-1:0] OFFSET_MAX = {POS_W{1'b1}};

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIENTATION  = 2'd0,
      CSR_SPACING      = 2'd1,
      CSR_FINAL_WIDTH  = 2'd2,
      CSR_FINAL_HEIGHT = 2'd3
   } csr_index_type;

   // Cross-axis alignment codes
   localparam logic [1:0] ALIGN_STRETCH = 2'd0;
   localparam logic [1:0] ALIGN_START   = 2'd1;
   localparam logic [1:0] ALIGN_CENTER  = 2'd2;
   localparam logic [1:0] ALIGN_END     = 2'd3;

   typedef struct packed {
      logic             first_child;
      logic             collapsed;
      logic [LEN_W-1:0] desired_width;
      logic [LEN_W-1:0] desired_height;
      logic [LEN_W-1:0] margin_left;
      logic [LEN_W-1:0] margin_top;
      logic [LEN_W-1:0] margin_right;
      logic [LEN_W-1:0] margin_bottom;
      logic [1:0]       cross_align;
   } req_payload_type;

   typedef struct packed {
      logic             placed;
      logic [POS_W-1:0] rect_x;
      logic [POS_W-1:0] rect_y;
      logic [LEN_W-1:0] rect_width;
      logic [LEN_W-1:0] rect_height;
      logic             offset_saturated;
   } rsp_payload_type;

endpackage

[hdl/sla_cross.sv]
// Cross-axis placement of one child: available extent, size and position.
module sla_cross (
   input  logic [sla_pkg::LEN_W-1:0] extent,
   input  logic [sla_pkg::LEN_W-1:0] lead,
   input  logic [sla_pkg::LEN_W-1:0] trail,
   input  logic [sla_pkg::LEN_W-1:0] desired,
   input  logic [1:0]                align,
   output logic [sla_pkg::LEN_W:0]   pos,
   output logic [sla_pkg::LEN_W-1:0] size
);

   logic [sla_pkg::LEN_W:0]   margins;
   logic [sla_pkg::LEN_W:0]   extent_ext;
   logic [sla_pkg::LEN_W:0]   avail_diff;
   logic [sla_pkg::LEN_W-1:0] avail;
   logic [sla_pkg::LEN_W-1:0] fit;
   logic [sla_pkg::LEN_W-1:0] slack;

   assign margins    = {1'b0, lead} + {1'b0, trail};
   assign extent_ext = {1'b0, extent};
   assign avail_diff = extent_ext - margins;
   // clamp at zero when the margins exceed the extent
   assign avail      = (extent_ext > margins) ? avail_diff[sla_pkg::LEN_W-1:0] : '0;
   assign fit        = (desired < avail) ? desired : avail;
   assign slack      = avail - fit;

   always_comb begin
      size = fit;
      pos  = {1'b0, lead};
      case (align)
         sla_pkg::ALIGN_STRETCH: size = avail;
         sla_pkg::ALIGN_START:   pos  = {1'b0, lead};
         sla_pkg::ALIGN_CENTER:  pos  = {1'b0, lead} + {2'b00, slack[sla_pkg::LEN_W-1:1]};
         sla_pkg::ALIGN_END:     pos  = {1'b0, lead} + {1'b0, slack};
         default:                pos  = {1'b0, lead};
      endcase
   end

endmodule

[hdl/stack_layout_arrange.sv]
// Stack panel arrange: places one child per transaction along the main axis.
// Latency: a result appears in the cycle after its request transaction.
// Throughput: one child per cycle while the result is not stalled; the running
// offset, trailing margin and placed flag are registered with the result when the request is taken.
// Reset clears the configuration registers, the pass state and the result
// valid flag; the block takes requests in the first cycle after reset.
module stack_layout_arrange (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  sla_pkg::req_payload_type         req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output sla_pkg::rsp_payload_type         rsp_payload,
   input  logic                             csr_we,
   input  logic [sla_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sla_pkg::LEN_W-1:0]        csr_wdata
);

   localparam int LW = sla_pkg::LEN_W;
   localparam int PW = sla_pkg::POS_W;

   logic          orientation_ff;
   logic [LW-1:0] spacing_ff;
   logic [LW-1:0] final_width_ff;
   logic [LW-1:0] final_height_ff;

   logic [PW-1:0] main_offset_ff, main_offset_in;
   logic [LW-1:0] trailing_ff, trailing_in;
   logic          any_placed_ff, any_placed_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   sla_pkg::rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic          accept;
   logic [PW-1:0] base_offset;
   logic [LW-1:0] base_trailing;
   logic          base_any;
   logic [LW-1:0] lead;
   logic [LW-1:0] max_tl;
   logic [LW-1:0] gap;
   logic [PW:0]   gap_sum;
   logic [PW-1:0] gap_offset;
   logic [LW-1:0] main_size;
   logic [PW:0]   end_sum;
   logic [PW-1:0] end_offset;

   logic [LW-1:0] cross_extent;
   logic [LW-1:0] cross_lead;
   logic [LW-1:0] cross_trail;
   logic [LW-1:0] cross_desired;
   logic [LW:0]   cross_pos;
   logic [LW-1:0] cross_size;
   logic [PW-1:0] cross_pos_ext;

   assign req_stall   = rsp_valid_ff & rsp_stall;
   assign accept      = req_valid & ~req_stall;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // A first child restarts the pass before it is handled
   assign base_offset   = req_payload.first_child ? '0 : main_offset_ff;
   assign base_trailing = req_payload.first_child ? '0 : trailing_ff;
   assign base_any      = req_payload.first_child ? 1'b0 : any_placed_ff;

   assign lead   = orientation_ff ? req_payload.margin_left : req_payload.margin_top;
   assign max_tl = (base_trailing > lead) ? base_trailing : lead;
   assign gap    = base_any ? ((max_tl > spacing_ff) ? max_tl : spacing_ff) : lead;

   // Saturating adds: the carry out means the offset ran past its maximum
   assign gap_sum    = {1'b0, base_offset} + {{(PW + 1 - LW){1'b0}}, gap};
   assign gap_offset = gap_sum[PW] ? sla_pkg::OFFSET_MAX : gap_sum[PW-1:0];

   assign main_size  = orientation_ff ? req_payload.desired_width
                                      : req_payload.desired_height;
   assign end_sum    = {1'b0, gap_offset} + {{(PW + 1 - LW){1'b0}}, main_size};
   assign end_offset = end_sum[PW] ? sla_pkg::OFFSET_MAX : end_sum[PW-1:0];

   assign cross_extent  = orientation_ff ? final_height_ff : final_width_ff;
   assign cross_lead    = orientation_ff ? req_payload.margin_top : req_payload.margin_left;
   assign cross_trail   = orientation_ff ? req_payload.margin_bottom
                                         : req_payload.margin_right;
   assign cross_desired = orientation_ff ? req_payload.desired_height
                                         : req_payload.desired_width;
   assign cross_pos_ext = {{(PW - LW - 1){1'b0}}, cross_pos};

   sla_cross u_cross (
      .extent  (cross_extent),
      .lead    (cross_lead),
      .trail   (cross_trail),
      .desired (cross_desired),
      .align   (req_payload.cross_align),
      .pos     (cross_pos),
      .size    (cross_size)
   );

   always_comb begin
      main_offset_in = base_offset;
      trailing_in    = base_trailing;
      any_placed_in  = base_any;
      rsp_payload_in = '0;
      if (!req_payload.collapsed) begin
         main_offset_in = end_offset;
         trailing_in    = orientation_ff ? req_payload.margin_right
                                         : req_payload.margin_bottom;
         any_placed_in  = 1'b1;
         rsp_payload_in.placed = 1'b1;
         if (orientation_ff) begin
            rsp_payload_in.rect_x      = gap_offset;
            rsp_payload_in.rect_y      = cross_pos_ext;
            rsp_payload_in.rect_width  = req_payload.desired_width;
            rsp_payload_in.rect_height = cross_size;
         end else begin
            rsp_payload_in.rect_x      = cross_pos_ext;
            rsp_payload_in.rect_y      = gap_offset;
            rsp_payload_in.rect_width  = cross_size;
            rsp_payload_in.rect_height = req_payload.desired_height;
         end
      end
      rsp_payload_in.offset_saturated = (main_offset_in == sla_pkg::OFFSET_MAX);
   end

   // Hold the result until taken; a new transaction may load the same cycle
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         orientation_ff  <= 1'b0;
         spacing_ff      <= '0;
         final_width_ff  <= '0;
         final_height_ff <= '0;
      end else if (csr_we) begin
         unique case (sla_pkg::csr_index_type'(csr_index))
            sla_pkg::CSR_ORIENTATION:  orientation_ff  <= csr_wdata[0];
            sla_pkg::CSR_SPACING:      spacing_ff      <= csr_wdata;
            sla_pkg::CSR_FINAL_WIDTH:  final_width_ff  <= csr_wdata;
            sla_pkg::CSR_FINAL_HEIGHT: final_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_offset_ff <= '0;
         trailing_ff    <= '0;
         any_placed_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            main_offset_ff <= main_offset_in;
            trailing_ff    <= trailing_in;
            any_placed_ff  <= any_placed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

endmodule

[tb/tb_stack_layout_arrange.sv]
// Self-checking testbench for the stack panel arrange block: random and directed children.
module tb_stack_layout_arrange;
   import sla_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PRINT_LIMIT = 200;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [LEN_W-1:0]      csr_wdata = '0;

   // Layout registers as the block should hold them
   logic                  cfg_horizontal = 1'b0;
   logic [LEN_W-1:0]      cfg_spacing = '0;
   logic [LEN_W-1:0]      cfg_width = '0;
   logic [LEN_W-1:0]      cfg_height = '0;

   // Running pass state
   logic [POS_W-1:0]      pass_offset = '0;
   logic [LEN_W-1:0]      pass_trail = '0;
   logic                  pass_any = 1'b0;

   req_payload_type       child_q[$];
   rsp_payload_type       placement_q[$];
   bit                    idling_on = 1'b1;
   int unsigned           gap_left = 0;
   int unsigned           stall_left = 0;
   int unsigned           error_count = 0;
   int unsigned           cycle_count = 0;

   stack_layout_arrange u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic report_mismatch(string what);
      if (error_count < PRINT_LIMIT)
         $display("[%0t] mismatch: %s", $realtime, what);
      error_count++;
   endtask

   task automatic check_field(string name, logic [POS_W-1:0] got, logic [POS_W-1:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
   endtask

   function automatic logic [POS_W-1:0] offset_add(logic [POS_W-1:0] a, logic [LEN_W-1:0] b);
      logic [POS_W:0] sum;
      sum = {1'b0, a} + {{(POS_W + 1 - LEN_W){1'b0}}, b};
      return (sum > OFFSET_MAX) ? OFFSET_MAX : sum[POS_W-1:0];
   endfunction

   // Fit a child across the panel between its two cross margins
   function automatic void cross_fit(input logic [LEN_W-1:0] extent, lead, trail, desired,
                                     input logic [1:0] align,
                                     output logic [POS_W-1:0] pos,
                                     output logic [LEN_W-1:0] size);
      logic [LEN_W:0]   margins;
      logic [LEN_W-1:0] avail;
      margins = {1'b0, lead} + {1'b0, trail};
      avail = ({1'b0, extent} > margins) ? LEN_W'({1'b0, extent} - margins) : '0;
      size = (desired < avail) ? desired : avail;
      pos = POS_W'(lead);
      case (align)
         ALIGN_STRETCH: size = avail;
         ALIGN_CENTER:  pos = POS_W'(lead) + POS_W'((avail - size) >> 1);
         ALIGN_END:     pos = POS_W'(lead) + POS_W'(avail - size);
         default: ;
      endcase
   endfunction

   function automatic rsp_payload_type arrange_child(req_payload_type c);
      rsp_payload_type  r;
      logic [LEN_W-1:0] lead;
      logic [LEN_W-1:0] gap;
      logic [POS_W-1:0] pos;
      logic [LEN_W-1:0] size;
      r = '0;
      if (c.first_child) begin
         pass_offset = '0;
         pass_trail = '0;
         pass_any = 1'b0;
      end
      if (!c.collapsed) begin
         lead = cfg_horizontal ? c.margin_left : c.margin_top;
         gap = lead;
         // collapse margins against the previous child
         if (pass_any) begin
            if (pass_trail > gap) gap = pass_trail;
            if (cfg_spacing > gap) gap = cfg_spacing;
         end
         pass_offset = offset_add(pass_offset, gap);
         if (!cfg_horizontal) begin
            cross_fit(cfg_width, c.margin_left, c.margin_right, c.desired_width,
                      c.cross_align, pos, size);
            r.rect_x = pos;
            r.rect_width = size;
            r.rect_y = pass_offset;
            r.rect_height = c.desired_height;
            pass_offset = offset_add(pass_offset, c.desired_height);
            pass_trail = c.margin_bottom;
         end else begin
            cross_fit(cfg_height, c.margin_top, c.margin_bottom, c.desired_height,
                      c.cross_align, pos, size);
            r.rect_y = pos;
            r.rect_height = size;
            r.rect_x = pass_offset;
            r.rect_width = c.desired_width;
            pass_offset = offset_add(pass_offset, c.desired_width);
            pass_trail = c.margin_right;
         end
         pass_any = 1'b1;
         r.placed = 1'b1;
      end
      r.offset_saturated = (pass_offset == OFFSET_MAX);
      return r;
   endfunction

   // Request driver: predict on each accepted transaction, hold while stalled
   always @(posedge clock) begin : child_driver
      logic taken;
      taken = req_valid && !req_stall;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (taken)
            placement_q.push_back(arrange_child(req_payload));
         if (req_valid && !taken) begin
         end else if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (child_q.size() != 0 && idling_on && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(0, 11);
            req_valid <= 1'b0;
         end else if (child_q.size() != 0) begin
            req_valid <= 1'b1;
            req_payload <= child_q.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result monitor and stall generator
   always @(posedge clock) begin : placement_monitor
      rsp_payload_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (placement_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result 0x%0h", rsp_payload));
            end else begin
               want = placement_q.pop_front();
               check_field("placed", POS_W'(rsp_payload.placed), POS_W'(want.placed));
               check_field("rect_x", rsp_payload.rect_x, want.rect_x);
               check_field("rect_y", rsp_payload.rect_y, want.rect_y);
               check_field("rect_width", POS_W'(rsp_payload.rect_width),
                           POS_W'(want.rect_width));
               check_field("rect_height", POS_W'(rsp_payload.rect_height),
                           POS_W'(want.rect_height));
               check_field("offset_saturated", POS_W'(rsp_payload.offset_saturated),
                           POS_W'(want.offset_saturated));
            end
         end
         if (stall_left != 0)
            stall_left--;
         else if (idling_on && $urandom_range(0, 6) == 0)
            stall_left = $urandom_range(1, 12);
         rsp_stall <= (stall_left != 0);
      end
   end

   function automatic req_payload_type make_child(bit first, bit coll,
                                                  logic [LEN_W-1:0] dw, dh, ml, mt, mr, mb,
                                                  logic [1:0] align);
      req_payload_type c;
      c.first_child = first;
      c.collapsed = coll;
      c.desired_width = dw;
      c.desired_height = dh;
      c.margin_left = ml;
      c.margin_top = mt;
      c.margin_right = mr;
      c.margin_bottom = mb;
      c.cross_align = align;
      return c;
   endfunction

   function automatic logic [LEN_W-1:0] pick_len(bit heavy);
      if (heavy) begin
         if ($urandom_range(0, 3) == 0) return LEN_W'($urandom);
         return LEN_W'($urandom_range(16'h8000, 16'hFFFF));
      end
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 16'hFFFF;
         2, 3:    return LEN_W'($urandom);
         default: return LEN_W'($urandom_range(0, 16'h0400));
      endcase
   endfunction

   // Mostly proper passes; some start without a first flag or restart midway
   task automatic add_random_passes(int unsigned count);
      int unsigned left;
      int unsigned run;
      bit          heavy;
      bit          first;
      left = count;
      while (left != 0) begin
         heavy = ($urandom_range(0, 4) == 0);
         run = $urandom_range(1, heavy ? 16 : 10);
         for (int i = 0; i < run && left != 0; i++) begin
            first = (i == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0);
            child_q.push_back(make_child(first, $urandom_range(0, 7) == 0,
                                         pick_len(heavy), pick_len(heavy), pick_len(heavy),
                                         pick_len(heavy), pick_len(heavy), pick_len(heavy),
                                         2'($urandom_range(0, 3))));
            left--;
         end
      end
   endtask

   task automatic write_reg(csr_index_type idx, logic [LEN_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_ORIENTATION:  cfg_horizontal = value[0];
         CSR_SPACING:      cfg_spacing = value;
         CSR_FINAL_WIDTH:  cfg_width = value;
         CSR_FINAL_HEIGHT: cfg_height = value;
         default: ;
      endcase
   endtask

   task automatic set_layout(bit horiz, logic [LEN_W-1:0] sp, w, h);
      write_reg(CSR_ORIENTATION, {15'($urandom), horiz});
      write_reg(CSR_SPACING, sp);
      write_reg(CSR_FINAL_WIDTH, w);
      write_reg(CSR_FINAL_HEIGHT, h);
      @(posedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (child_q.size() != 0 || req_valid || placement_q.size() != 0)
         @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   initial begin : stimulus
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Vertical stack: every alignment, margin collapse, collapsed children
      set_layout(1'b0, 16'h0020, 16'h0640, 16'h0400);
      child_q.push_back(make_child(1, 0, 16'h0100, 16'h0080, 16'h0010, 16'h0018,
                                   16'h0020, 16'h0008, ALIGN_STRETCH));
      child_q.push_back(make_child(0, 0, 16'h0200, 16'h0040, 16'h0008, 16'h0004,
                                   16'h0010, 16'h0030, ALIGN_START));
      child_q.push_back(make_child(0, 0, 16'h0101, 16'h0010, 16'h0000, 16'h0050,
                                   16'h0000, 16'h0000, ALIGN_CENTER));
      child_q.push_back(make_child(0, 0, 16'h0300, 16'h0020, 16'h0040, 16'h0000,
                                   16'h0060, 16'h0010, ALIGN_END));
      child_q.push_back(make_child(0, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                   16'hFFFF, 16'hFFFF, ALIGN_END));
      child_q.push_back(make_child(0, 0, 16'hFFFF, 16'h0030, 16'h0011, 16'h0002,
                                   16'h0020, 16'h0000, ALIGN_CENTER));
      child_q.push_back(make_child(0, 0, 16'h0080, 16'h0010, 16'h0400, 16'h0000,
                                   16'h0300, 16'h0000, ALIGN_STRETCH));
      child_q.push_back(make_child(0, 0, 16'h0080, 16'h0010, 16'h0320, 16'h0000,
                                   16'h0320, 16'h0000, ALIGN_END));
      child_q.push_back(make_child(1, 1, 16'h0040, 16'h0040, 16'h0010, 16'h0010,
                                   16'h0010, 16'h0010, ALIGN_START));
      child_q.push_back(make_child(0, 0, 16'h0040, 16'h0040, 16'h0010, 16'h0070,
                                   16'h0010, 16'h0010, ALIGN_START));
      child_q.push_back(make_child(0, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                   16'h0000, 16'h0000, ALIGN_STRETCH));
      // drive the offset into saturation, then check it sticks
      for (int i = 0; i < 9; i++)
         child_q.push_back(make_child(i == 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                      16'hFFFF, 16'hFFFF, ALIGN_END));
      child_q.push_back(make_child(0, 1, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                   16'h0000, 16'h0000, ALIGN_START));
      child_q.push_back(make_child(0, 0, 16'h0010, 16'h0010, 16'h0000, 16'h0000,
                                   16'h0000, 16'h0000, ALIGN_START));
      child_q.push_back(make_child(1, 0, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                   16'h0000, 16'h0000, ALIGN_CENTER));
      wait_drained();

      // Horizontal stack, then random passes
      set_layout(1'b1, 16'h0000, 16'h0800, 16'h0300);
      child_q.push_back(make_child(1, 0, 16'h0100, 16'h0080, 16'h0010, 16'h0018,
                                   16'h0020, 16'h0008, ALIGN_STRETCH));
      child_q.push_back(make_child(0, 0, 16'h0040, 16'h0101, 16'h0004, 16'h0000,
                                   16'h0020, 16'h0000, ALIGN_CENTER));
      child_q.push_back(make_child(0, 0, 16'h0040, 16'h0100, 16'h0030, 16'h0010,
                                   16'h0000, 16'h0020, ALIGN_END));
      add_random_passes(80);
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         case (p)
            0: set_layout(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            1: set_layout(1'b1, 16'hFFFF, 16'h0000, 16'h0000);
            2: set_layout(1'b0, 16'h0000, 16'h0000, 16'hFFFF);
            3: set_layout(1'b1, 16'h0000, 16'hFFFF, LEN_W'($urandom));
            4: set_layout(1'b0, LEN_W'($urandom_range(0, 16'h0100)), LEN_W'($urandom),
                          LEN_W'($urandom));
            default: begin
               set_layout(1'($urandom), LEN_W'($urandom_range(0, 16'h0100)),
                          LEN_W'($urandom), LEN_W'($urandom));
               // back-to-back traffic to finish
               idling_on = 1'b0;
            end
         endcase
         add_random_passes(80);
         wait_drained();
      end

      repeat (4) @(posedge clock);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
